@@ hw/rtl/zss_pkg.sv @@
package zss_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 65536;
  localparam int COL_W       = 6;
  localparam int CNT_W       = 7;
  localparam int ROWS_W      = 17;
  localparam int SUM_W       = 32;
  localparam int SQ_W        = 48;
  localparam int MEAN_W      = 16;
  localparam int INV_W       = 32;
  localparam int ACC_W       = ROWS_W + SQ_W + SUM_W;
  localparam int STAT_W      = INV_W + MEAN_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_W       = 7;
  localparam int DIV_STEPS   = 41;

  localparam logic [CFG_IDX_W-1:0] CFG_SUBTRACT_MEAN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIVIDE        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 2'd2;

  localparam logic OP_FIT       = 1'b0;
  localparam logic OP_TRANSFORM = 1'b1;

  localparam logic KIND_TRANSFORM = 1'b0;
  localparam logic KIND_FIT       = 1'b1;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_BAD_COLUMN   = 3'd1;
  localparam logic [2:0] ST_ZERO_DEV     = 3'd2;
  localparam logic [2:0] ST_NOT_FITTED   = 3'd3;
  localparam logic [2:0] ST_ROW_OVERFLOW = 3'd4;

  typedef struct packed {
    logic               op;
    logic [COL_W-1:0]   column;
    logic signed [15:0] sample_value;
    logic               last_of_fit;
  } req_t;

  typedef struct packed {
    logic signed [15:0] scaled_value;
    logic               result_kind;
    logic [2:0]         status;
  } rsp_t;

endpackage

@@ hw/rtl/zss_ram.sv @@
module zss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/zscore_standard_scaler_unit.sv @@
// Fit sample: the fit state registers its result, if any, for the strobe.
// Transform sample: the read state registers the product and the multiply state the
// rounded, saturated result; bad column, not fitted or zero deviation skip the multiply.
// Last fit sample: a column walk over all 64 columns, each through a 32-step square root
// and one shared 41-step divider, used for the mean and then the inverse deviation.
// One request at a time, busy until done and any result strobed. Results cannot be stalled.
// Reset restores default config, invalidates all accumulators and clears the fitted flag.
module zscore_standard_scaler_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  zss_pkg::req_t                        req_i,
  output logic                                 result_valid_o,
  output zss_pkg::rsp_t                        result_o,
  input  logic                                 cfg_we_i,
  input  logic [zss_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [zss_pkg::CFG_W-1:0]            cfg_wdata_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FIT  = 4'd1;
  localparam logic [3:0] S_TRD  = 4'd2;
  localparam logic [3:0] S_TMUL = 4'd3;
  localparam logic [3:0] S_WRD  = 4'd4;
  localparam logic [3:0] S_WLD  = 4'd5;
  localparam logic [3:0] S_WM1  = 4'd6;
  localparam logic [3:0] S_WM2  = 4'd7;
  localparam logic [3:0] S_WM3  = 4'd8;
  localparam logic [3:0] S_WD   = 4'd9;
  localparam logic [3:0] S_WSQ  = 4'd10;
  localparam logic [3:0] S_WDM  = 4'd11;
  localparam logic [3:0] S_WIS  = 4'd12;
  localparam logic [3:0] S_WDI  = 4'd13;
  localparam logic [3:0] S_WWR  = 4'd14;

  localparam logic [zss_pkg::COL_W-1:0] LAST_COL = zss_pkg::COL_W'(zss_pkg::MAX_COLUMNS - 1);

  logic [3:0] state_q, state_d;
  zss_pkg::req_t req_q, req_d;
  logic bad_q, bad_d;
  logic vld_bit_q, vld_bit_d;
  logic cfg_sub_q, cfg_sub_d;
  logic cfg_div_q, cfg_div_d;
  logic [zss_pkg::CNT_W-1:0] cfg_cnt_q, cfg_cnt_d;
  logic [zss_pkg::MAX_COLUMNS-1:0] acc_vld_q, acc_vld_d;
  logic fitted_q, fitted_d;
  logic [zss_pkg::COL_W-1:0] col_q, col_d;
  logic [2:0] st_q, st_d;
  logic zd_q, zd_d;
  zss_pkg::rsp_t rsp_q, rsp_d;
  logic rsp_vld_q, rsp_vld_d;

  logic [zss_pkg::ROWS_W-1:0] n_q, n_d;
  logic signed [zss_pkg::SUM_W-1:0] s_q, s_d;
  logic [zss_pkg::SQ_W-1:0] qsum_q, qsum_d;
  logic [40:0] pa_q, pa_d, pb_q, pb_d;
  logic [63:0] np_q, np_d, sq_q, sq_d;
  logic [63:0] sqv_q, sqv_d, res_q, res_d, bit_q, bit_d;
  logic [zss_pkg::MEAN_W-1:0] mean_q, mean_d;
  logic [zss_pkg::INV_W-1:0] inv_q, inv_d;
  logic dneg_q, dneg_d;
  logic [31:0] div_rem_q, div_rem_d, div_den_q, div_den_d;
  logic [40:0] div_quo_q, div_quo_d;
  logic [5:0] div_cnt_q, div_cnt_d;
  logic signed [49:0] prod_q, prod_d;

  logic accept;
  logic [zss_pkg::CNT_W-1:0] lim;
  logic [zss_pkg::COL_W-1:0] acc_raddr;
  logic acc_we, stat_we;
  logic [zss_pkg::ACC_W-1:0] acc_wdata, acc_rdata;
  logic [zss_pkg::STAT_W-1:0] stat_wdata, stat_rdata;
  logic [zss_pkg::SUM_W-1:0] rd_sum;
  logic [zss_pkg::SQ_W-1:0] rd_sq;
  logic [zss_pkg::ROWS_W-1:0] rd_rows;
  logic signed [31:0] x_sq;
  logic [31:0] abs_s;
  logic signed [33:0] nsum;
  logic [33:0] nsum_abs;
  logic [32:0] div_sh;
  logic div_ge;
  logic signed [41:0] mfull;
  logic signed [16:0] diff;
  logic signed [32:0] inv_s;
  logic signed [50:0] tp;
  logic signed [34:0] tq;
  logic [63:0] sq_try;

  assign accept = start && !busy;
  assign busy = (state_q != S_IDLE);
  assign lim = (cfg_cnt_q < zss_pkg::CNT_W'(zss_pkg::MAX_COLUMNS)) ? cfg_cnt_q
             : zss_pkg::CNT_W'(zss_pkg::MAX_COLUMNS);
  assign acc_raddr = (state_q == S_IDLE) ? req_i.column : col_q;

  assign rd_sum  = vld_bit_q ? acc_rdata[zss_pkg::SUM_W-1:0] : '0;
  assign rd_sq   = vld_bit_q ? acc_rdata[zss_pkg::SUM_W +: zss_pkg::SQ_W] : '0;
  assign rd_rows = vld_bit_q ? acc_rdata[zss_pkg::SUM_W+zss_pkg::SQ_W +: zss_pkg::ROWS_W] : '0;

  assign x_sq = 32'(req_q.sample_value) * 32'(req_q.sample_value);
  assign abs_s = s_q[31] ? 32'(-s_q) : 32'(s_q);
  assign nsum = $signed({s_q[31], s_q, 1'b0}) + $signed({17'b0, n_q});
  assign nsum_abs = nsum[33] ? 34'(-nsum) : 34'(nsum);
  assign div_sh = {div_rem_q, div_quo_q[40]};
  assign div_ge = (div_sh >= {1'b0, div_den_q});
  assign mfull = dneg_q ? (-$signed({1'b0, div_quo_q}) - ((div_rem_q != '0) ? 42'sd1 : 42'sd0))
                        : $signed({1'b0, div_quo_q});
  assign sq_try = res_q + bit_q;
  assign diff = 17'(req_q.sample_value) - 17'($signed(stat_rdata[zss_pkg::MEAN_W-1:0]));
  assign inv_s = $signed({1'b0, stat_rdata[zss_pkg::STAT_W-1:zss_pkg::MEAN_W]});
  assign tp = 51'(prod_q) + 51'sd32768;
  assign tq = tp[50:16];

  always_comb begin
    state_d = state_q;
    req_d = req_q;
    bad_d = bad_q;
    vld_bit_d = vld_bit_q;
    cfg_sub_d = cfg_sub_q;
    cfg_div_d = cfg_div_q;
    cfg_cnt_d = cfg_cnt_q;
    acc_vld_d = acc_vld_q;
    fitted_d = fitted_q;
    col_d = col_q;
    st_d = st_q;
    zd_d = zd_q;
    rsp_d = rsp_q;
    rsp_vld_d = 1'b0;
    n_d = n_q;
    s_d = s_q;
    qsum_d = qsum_q;
    pa_d = pa_q;
    pb_d = pb_q;
    np_d = np_q;
    sq_d = sq_q;
    sqv_d = sqv_q;
    res_d = res_q;
    bit_d = bit_q;
    mean_d = mean_q;
    inv_d = inv_q;
    dneg_d = dneg_q;
    div_rem_d = div_rem_q;
    div_den_d = div_den_q;
    div_quo_d = div_quo_q;
    div_cnt_d = div_cnt_q;
    prod_d = prod_q;
    acc_we = 1'b0;
    acc_wdata = {rd_rows + 17'd1, rd_sq + 48'(unsigned'(x_sq)), rd_sum + 32'(req_q.sample_value)};
    stat_we = 1'b0;
    stat_wdata = {inv_q, cfg_sub_q ? mean_q : 16'd0};

    if (cfg_we_i) begin
      case (cfg_idx_i)
        zss_pkg::CFG_SUBTRACT_MEAN: cfg_sub_d = cfg_wdata_i[0];
        zss_pkg::CFG_DIVIDE:        cfg_div_d = cfg_wdata_i[0];
        zss_pkg::CFG_COLUMN_COUNT:  cfg_cnt_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if ((state_q == S_WDM || state_q == S_WDI) && div_cnt_q != 6'(zss_pkg::DIV_STEPS)) begin
      div_rem_d = div_ge ? 32'(div_sh - {1'b0, div_den_q}) : div_sh[31:0];
      div_quo_d = {div_quo_q[39:0], div_ge};
      div_cnt_d = div_cnt_q + 6'd1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d = req_i;
          bad_d = ({1'b0, req_i.column} >= lim);
          vld_bit_d = acc_vld_q[req_i.column];
          state_d = (req_i.op == zss_pkg::OP_FIT) ? S_FIT : S_TRD;
        end
      end
      S_FIT: begin
        if (bad_q) begin
          st_d = zss_pkg::ST_BAD_COLUMN;
        end else if (rd_rows >= zss_pkg::ROWS_W'(zss_pkg::MAX_ROWS)) begin
          st_d = zss_pkg::ST_ROW_OVERFLOW;
        end else begin
          st_d = zss_pkg::ST_OK;
          acc_we = 1'b1;
          acc_vld_d[req_q.column] = 1'b1;
        end
        if (req_q.last_of_fit) begin
          col_d = '0;
          zd_d = 1'b0;
          state_d = S_WRD;
        end else begin
          if (st_d != zss_pkg::ST_OK) begin
            rsp_vld_d = 1'b1;
            rsp_d = '{scaled_value: '0, result_kind: zss_pkg::KIND_FIT, status: st_d};
          end
          state_d = S_IDLE;
        end
      end
      S_TRD: begin
        rsp_d = '{scaled_value: '0, result_kind: zss_pkg::KIND_TRANSFORM,
                  status: zss_pkg::ST_OK};
        prod_d = diff * inv_s;
        state_d = S_IDLE;
        if (bad_q) begin
          rsp_d.status = zss_pkg::ST_BAD_COLUMN;
          rsp_vld_d = 1'b1;
        end else if (!fitted_q) begin
          rsp_d.status = zss_pkg::ST_NOT_FITTED;
          rsp_vld_d = 1'b1;
        end else if (inv_s == '0) begin
          rsp_d.status = zss_pkg::ST_ZERO_DEV;
          rsp_vld_d = 1'b1;
        end else begin
          state_d = S_TMUL;
        end
      end
      S_TMUL: begin
        rsp_vld_d = 1'b1;
        rsp_d.result_kind = zss_pkg::KIND_TRANSFORM;
        rsp_d.status = zss_pkg::ST_OK;
        if (tq > 35'sd32767) begin
          rsp_d.scaled_value = 16'sh7FFF;
        end else if (tq < -35'sd32768) begin
          rsp_d.scaled_value = 16'sh8000;
        end else begin
          rsp_d.scaled_value = tq[15:0];
        end
        state_d = S_IDLE;
      end
      S_WRD: begin
        vld_bit_d = acc_vld_q[col_q];
        state_d = S_WLD;
      end
      S_WLD: begin
        n_d = rd_rows;
        s_d = rd_sum;
        qsum_d = rd_sq;
        state_d = S_WM1;
      end
      S_WM1: begin
        pa_d = 41'(n_q) * 41'(qsum_q[23:0]);
        state_d = S_WM2;
      end
      S_WM2: begin
        pb_d = 41'(n_q) * 41'(qsum_q[47:24]);
        state_d = S_WM3;
      end
      S_WM3: begin
        sq_d = 64'(abs_s) * 64'(abs_s);
        np_d = 64'(pa_q) + {pb_q[39:0], 24'b0};
        state_d = S_WD;
      end
      S_WD: begin
        sqv_d = np_q - sq_q;
        res_d = '0;
        bit_d = 64'd1 << 62;
        state_d = S_WSQ;
      end
      S_WSQ: begin
        if (bit_q != '0) begin
          if (sqv_q >= sq_try) begin
            sqv_d = sqv_q - sq_try;
            res_d = (res_q >> 1) + bit_q;
          end else begin
            res_d = res_q >> 1;
          end
          bit_d = bit_q >> 2;
        end else if (n_q == '0) begin
          mean_d = '0;
          state_d = S_WIS;
        end else begin
          dneg_d = nsum[33];
          div_quo_d = 41'(nsum_abs);
          div_rem_d = '0;
          div_den_d = {14'b0, n_q, 1'b0};
          div_cnt_d = '0;
          state_d = S_WDM;
        end
      end
      S_WDM: begin
        if (div_cnt_q == 6'(zss_pkg::DIV_STEPS)) begin
          if (mfull > 42'sd32767) begin
            mean_d = 16'h7FFF;
          end else if (mfull < -42'sd32768) begin
            mean_d = 16'h8000;
          end else begin
            mean_d = mfull[15:0];
          end
          state_d = S_WIS;
        end
      end
      S_WIS: begin
        if (!cfg_div_q) begin
          inv_d = 32'd65536;
          state_d = S_WWR;
        end else if (res_q[31:0] == '0) begin
          inv_d = '0;
          if ({1'b0, col_q} < lim) begin
            zd_d = 1'b1;
          end
          state_d = S_WWR;
        end else begin
          div_quo_d = {n_q, 24'b0} + 41'(res_q[31:1]);
          div_rem_d = '0;
          div_den_d = res_q[31:0];
          div_cnt_d = '0;
          state_d = S_WDI;
        end
      end
      S_WDI: begin
        if (div_cnt_q == 6'(zss_pkg::DIV_STEPS)) begin
          inv_d = (div_quo_q[40:32] != '0) ? '1 : div_quo_q[31:0];
          state_d = S_WWR;
        end
      end
      S_WWR: begin
        stat_we = 1'b1;
        if (col_q == LAST_COL) begin
          acc_vld_d = '0;
          fitted_d = 1'b1;
          rsp_vld_d = 1'b1;
          rsp_d = '{scaled_value: '0, result_kind: zss_pkg::KIND_FIT,
                    status: (st_q != zss_pkg::ST_OK) ? st_q
                          : (zd_q ? zss_pkg::ST_ZERO_DEV : zss_pkg::ST_OK)};
          state_d = S_IDLE;
        end else begin
          col_d = col_q + 6'd1;
          state_d = S_WRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_sub_q <= 1'b1;
      cfg_div_q <= 1'b1;
      cfg_cnt_q <= zss_pkg::CNT_W'(1);
      acc_vld_q <= '0;
      fitted_q <= 1'b0;
      rsp_vld_q <= 1'b0;
      div_cnt_q <= '0;
      col_q <= '0;
    end else begin
      state_q <= state_d;
      cfg_sub_q <= cfg_sub_d;
      cfg_div_q <= cfg_div_d;
      cfg_cnt_q <= cfg_cnt_d;
      acc_vld_q <= acc_vld_d;
      fitted_q <= fitted_d;
      rsp_vld_q <= rsp_vld_d;
      div_cnt_q <= div_cnt_d;
      col_q <= col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    bad_q <= bad_d;
    vld_bit_q <= vld_bit_d;
    st_q <= st_d;
    zd_q <= zd_d;
    rsp_q <= rsp_d;
    n_q <= n_d;
    s_q <= s_d;
    qsum_q <= qsum_d;
    pa_q <= pa_d;
    pb_q <= pb_d;
    np_q <= np_d;
    sq_q <= sq_d;
    sqv_q <= sqv_d;
    res_q <= res_d;
    bit_q <= bit_d;
    mean_q <= mean_d;
    inv_q <= inv_d;
    dneg_q <= dneg_d;
    div_rem_q <= div_rem_d;
    div_den_q <= div_den_d;
    div_quo_q <= div_quo_d;
    prod_q <= prod_d;
  end

  zss_ram #(
    .WIDTH(zss_pkg::ACC_W),
    .DEPTH(zss_pkg::MAX_COLUMNS)
  ) u_acc_ram (
    .clk_i  (clk_i),
    .we_i   (acc_we),
    .waddr_i(req_q.column),
    .wdata_i(acc_wdata),
    .raddr_i(acc_raddr),
    .rdata_o(acc_rdata)
  );

  zss_ram #(
    .WIDTH(zss_pkg::STAT_W),
    .DEPTH(zss_pkg::MAX_COLUMNS)
  ) u_stat_ram (
    .clk_i  (clk_i),
    .we_i   (stat_we),
    .waddr_i(col_q),
    .wdata_i(stat_wdata),
    .raddr_i(req_i.column),
    .rdata_o(stat_rdata)
  );

  assign result_valid_o = rsp_vld_q;
  assign result_o = rsp_q;

  a_result_follows_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a request in flight");

  a_walk_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WWR && col_q == LAST_COL) |=> (acc_vld_q == '0 && fitted_q))
    else $error("accumulators not cleared after column walk");

  a_ok_transform_fitted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.result_kind == zss_pkg::KIND_TRANSFORM
     && result_o.status == zss_pkg::ST_OK) |-> fitted_q)
    else $error("transform result before fit");

endmodule
